// ===== rtl/dtd_pkg.sv =====
// dtd_pkg: shared types and constants for the double transposition decryptor
// depends on nothing; used by dtd_ctrl, dtd_datapath and the top level

package dtd_pkg;

  // configuration register indexes
  localparam logic REG_ROW_PERM = 1'b0;
  localparam logic REG_COL_PERM = 1'b1;

  // reset keys packed three bits per entry, entry 0 lowest
  // row key {4,6,5,3,1,2}, column key {3,2,6,1,5,4}; wide enough for eight entries
  localparam logic [23:0] ROW_KEY_RST = 24'd71540;
  localparam logic [23:0] COL_KEY_RST = 24'd152467;

  // controller states
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic wr;    // take the input beat into the grid
    logic rd;    // read the next cell into the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic block_end;  // the input beat on offer closes the block
    logic read_last;  // the cell being read is the final one
    logic out_free;   // output register can take a new cell
  } sts_t;

endpackage

// ===== rtl/dtd_ctrl.sv =====
// dtd_ctrl: load / emit controller of the double transposition decryptor
// depends on dtd_pkg

module dtd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  dtd_pkg::sts_t  sts,
  output dtd_pkg::cmd_t  cmd
);

  dtd_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtd_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd.wr    = 1'b0;
    cmd.rd    = 1'b0;
    case (state_r)
      dtd_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        cmd.wr    = in_tvalid;
        if (in_tvalid && sts.block_end) begin
          state_nxt = dtd_pkg::ST_EMIT;
        end
      end
      dtd_pkg::ST_EMIT: begin
        cmd.rd = sts.out_free;
        if (sts.out_free && sts.read_last) begin
          state_nxt = dtd_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = dtd_pkg::ST_LOAD;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_block_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr && sts.block_end |=> state_r == dtd_pkg::ST_EMIT)
    else $error("closing beat did not start readout");

  a_last_read_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd && sts.read_last |=> state_r == dtd_pkg::ST_LOAD)
    else $error("final cell read did not return to loading");

  a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr && cmd.rd))
    else $error("grid written and read in the same cycle");
`endif

endmodule

// ===== rtl/dtd_datapath.sv =====
// dtd_datapath: key registers, grid memory with valid bits, fill and read counters,
// output register; depends on dtd_pkg

module dtd_datapath #(
  parameter int SIDE = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [3*SIDE-1:0]     cfg_wdata,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tlast,
  output logic [7:0]            out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_tlast,
  input  dtd_pkg::cmd_t         cmd,
  output dtd_pkg::sts_t         sts
);

  localparam int KW    = 3 * SIDE;
  localparam int CELLS = SIDE * SIDE;
  localparam int SW    = $clog2(SIDE);
  localparam int AW    = $clog2(CELLS);
  localparam logic [SW-1:0] LAST_IDX = SW'(SIDE - 1);

  logic [KW-1:0] row_key_r;
  logic [KW-1:0] col_key_r;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_key_r <= dtd_pkg::ROW_KEY_RST[KW-1:0];
      col_key_r <= dtd_pkg::COL_KEY_RST[KW-1:0];
    end else if (cfg_we) begin
      case (cfg_addr)
        dtd_pkg::REG_ROW_PERM: row_key_r <= cfg_wdata;
        dtd_pkg::REG_COL_PERM: col_key_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // fill position: fi is the key row index, fj the key column index
  logic [SW-1:0] fi_r, fj_r;
  logic          fill_last;
  logic [2:0]    key_r_ent, key_c_ent;
  logic [2:0]    r_m1, c_m1;
  logic          in_range;
  logic [AW-1:0] waddr;

  assign fill_last = (fi_r == LAST_IDX) && (fj_r == LAST_IDX);
  assign key_r_ent = col_key_r[3*fi_r +: 3];
  assign key_c_ent = row_key_r[3*fj_r +: 3];
  assign r_m1      = key_r_ent - 3'd1;
  assign c_m1      = key_c_ent - 3'd1;
  assign in_range  = (key_r_ent != 3'd0) && ({1'b0, key_r_ent} <= 4'(SIDE)) &&
                     (key_c_ent != 3'd0) && ({1'b0, key_c_ent} <= 4'(SIDE));
  assign waddr     = AW'(AW'(r_m1) * AW'(SIDE) + AW'(c_m1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fi_r <= '0;
      fj_r <= '0;
    end else if (cmd.wr) begin
      if (fill_last || in_tlast) begin
        fi_r <= '0;
        fj_r <= '0;
      end else if (fj_r == LAST_IDX) begin
        fj_r <= '0;
        fi_r <= fi_r + 1'b1;
      end else begin
        fj_r <= fj_r + 1'b1;
      end
    end
  end

  // read position: ri is the grid column (outer), rj the grid row (fastest)
  logic [SW-1:0] ri_r, rj_r;
  logic          read_last;
  logic [AW-1:0] raddr;

  assign read_last = (ri_r == LAST_IDX) && (rj_r == LAST_IDX);
  assign raddr     = AW'(AW'(rj_r) * AW'(SIDE) + AW'(ri_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ri_r <= '0;
      rj_r <= '0;
    end else if (cmd.rd) begin
      if (read_last) begin
        ri_r <= '0;
        rj_r <= '0;
      end else if (rj_r == LAST_IDX) begin
        rj_r <= '0;
        ri_r <= ri_r + 1'b1;
      end else begin
        rj_r <= rj_r + 1'b1;
      end
    end
  end

  // grid memory, one write and one registered read port
  logic [7:0] grid_mem [CELLS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr && in_range) begin
      grid_mem[waddr] <= in_tdata;
    end
    if (cmd.rd) begin
      rdata_r <= grid_mem[raddr];
    end
  end

  // valid bits: a cell never written this block reads as zero
  logic [CELLS-1:0] valid_r;
  logic             hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (cmd.rd) begin
        hit_r <= valid_r[raddr];
      end
      if (cmd.rd && read_last) begin
        valid_r <= '0;
      end else if (cmd.wr && in_range) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  // output register
  logic out_valid_r;
  logic out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (cmd.rd) begin
      out_valid_r <= 1'b1;
      out_last_r  <= read_last;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tdata  = hit_r ? rdata_r : 8'd0;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;

  assign sts.block_end = fill_last || in_tlast;
  assign sts.read_last = read_last;
  assign sts.out_free  = !out_valid_r || out_tready;

`ifndef NO_ASSERTIONS
  a_grid_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd && read_last |=> valid_r == '0)
    else $error("grid not cleared after final cell");

  a_read_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> out_valid_r)
    else $error("cell read but output register empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !cmd.rd)
    else $error("cell read over a waiting result");
`endif

endmodule

// ===== rtl/double_transposition_decrypt_top.sv =====
// Double transposition decryptor on a SIDE by SIDE grid. Ciphertext bytes are taken one
// per cycle while loading and scattered into the grid by the two keys; a block closes
// after SIDE*SIDE bytes or on a beat with in_tlast set. The grid is then read out column
// by column, row fastest, one cell per cycle unless the output stalls, through the single
// read port of the grid memory; input is held off during readout. Cells not written in a
// block read as zero; per-cell valid bits clear all at once, so there is no clearing pass
// after reset. Keys must be written on the cfg port only while the block is idle (a rule
// for the user, not enforced by the block); an entry of 0 or above SIDE drops its byte.
// depends on dtd_pkg, dtd_ctrl, dtd_datapath

module double_transposition_decrypt_top #(
  parameter int SIDE = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration: index 0 row_perm, index 1 col_perm
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [3*SIDE-1:0]   cfg_wdata,
  // input channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] cipher_byte
  input  logic                in_tlast,   // end_of_message
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [7:0] plain_byte
  output logic                out_tlast   // last_of_block
);

  dtd_pkg::cmd_t cmd;
  dtd_pkg::sts_t sts;

  dtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtd_datapath #(
    .SIDE (SIDE)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
